// ===== rtl/core/tlc_pkg.sv =====
// ----------------------------------------------------------------------------
// Two-level cache tag model: shared definitions
// Configuration register indexes, port widths, reset values and access codes.
// ----------------------------------------------------------------------------
package tlc_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_OFFSET = 3'd0,
        CFG_L1_INDEX     = 3'd1,
        CFG_L1_WAY       = 3'd2,
        CFG_L2_INDEX     = 3'd3,
        CFG_L2_WAY       = 3'd4,
        CFG_WRITE_ALLOC  = 3'd5
    } t_cfg_idx;

    // Reset values of the configuration registers.
    localparam logic [3:0] RST_BLOCK_OFFSET = 4'd2;
    localparam logic [2:0] RST_L1_INDEX     = 3'd6;
    localparam logic [1:0] RST_L1_WAY       = 2'd2;
    localparam logic [3:0] RST_L2_INDEX     = 4'd8;
    localparam logic [1:0] RST_L2_WAY       = 2'd3;
    localparam logic       RST_WRITE_ALLOC  = 1'b1;

    // Access kind code for a write.
    localparam logic KIND_WRITE = 1'b1;

endpackage

// ===== rtl/core/tlc_set_store.sv =====
// ----------------------------------------------------------------------------
// Set store
// One row per set holding the tags, valid, dirty and age fields of all ways.
// Registered read, single write port, and a clearing pass over the state
// fields after reset.
// ----------------------------------------------------------------------------
module tlc_set_store #(
    parameter int SETS = 64,
    parameter int WAYS = 4,
    parameter int AGW  = 3,
    parameter int TW   = 32,
    localparam int IW  = (SETS > 1) ? $clog2(SETS) : 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [IW-1:0]                  i_rd_set,
    output logic [WAYS-1:0][TW-1:0]        o_tags,
    output logic [WAYS-1:0]                o_valid,
    output logic [WAYS-1:0]                o_dirty,
    output logic [WAYS-1:0][AGW-1:0]       o_age,
    input  logic                           i_wr_en,
    input  logic [IW-1:0]                  i_wr_set,
    input  logic [WAYS-1:0][TW-1:0]        i_wr_tags,
    input  logic [WAYS-1:0]                i_wr_valid,
    input  logic [WAYS-1:0]                i_wr_dirty,
    input  logic [WAYS-1:0][AGW-1:0]       i_wr_age,
    output logic                           o_busy
);

    localparam int MW = 2 * WAYS + WAYS * AGW;

    logic [WAYS-1:0][TW-1:0] r_tag_mem [SETS];
    logic [MW-1:0]           r_meta_mem [SETS];
    logic [WAYS-1:0][TW-1:0] r_rd_tags;
    logic [MW-1:0]           r_rd_meta;
    logic                    r_busy;
    logic [IW-1:0]           r_clr_idx;

    // Clearing sweep over all rows after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_idx <= '0;
        end else if (r_busy) begin
            if (r_clr_idx == IW'(SETS - 1)) begin
                r_busy <= 1'b0;
            end
            r_clr_idx <= r_clr_idx + IW'(1);
        end
    end

    // Write port: the sweep has priority over normal updates.
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_meta_mem[r_clr_idx] <= '0;
        end else if (i_wr_en) begin
            r_meta_mem[i_wr_set] <= {i_wr_valid, i_wr_dirty, i_wr_age};
            r_tag_mem[i_wr_set]  <= i_wr_tags;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rd_tags <= r_tag_mem[i_rd_set];
        r_rd_meta <= r_meta_mem[i_rd_set];
    end

    assign o_tags                    = r_rd_tags;
    assign {o_valid, o_dirty, o_age} = r_rd_meta;
    assign o_busy                    = r_busy;

endmodule

// ===== rtl/core/tlc_way_unit.sv =====
// ----------------------------------------------------------------------------
// Way unit
// Compares one set row against a tag, picks the replacement way and
// computes the LRU ages after a chosen way is touched.
// ----------------------------------------------------------------------------
module tlc_way_unit #(
    parameter int WAYS = 4,
    parameter int AGW  = 3,
    parameter int TW   = 32,
    localparam int WIW = (WAYS > 1) ? $clog2(WAYS) : 1
) (
    input  logic [AGW-1:0]             i_ways,
    input  logic [WAYS-1:0]            i_valid,
    input  logic [WAYS-1:0][AGW-1:0]   i_age,
    input  logic [WAYS-1:0][TW-1:0]    i_tags,
    input  logic [TW-1:0]              i_tag,
    input  logic [WIW-1:0]             i_touch,
    output logic                       o_hit,
    output logic [WIW-1:0]             o_hit_way,
    output logic [WIW-1:0]             o_vic_way,
    output logic [WAYS-1:0][AGW-1:0]   o_age
);

    logic [WAYS-1:0] w_in_use;

    // Ways beyond the configured count are ignored.
    always_comb begin
        for (int j = 0; j < WAYS; j++) begin
            w_in_use[j] = (AGW'(j) < i_ways);
        end
    end

    // Tag match: the lowest matching valid way wins.
    always_comb begin
        logic hit;
        logic [WIW-1:0] way;
        hit = 1'b0;
        way = '0;
        for (int j = 0; j < WAYS; j++) begin
            if (!hit && w_in_use[j] && i_valid[j] && (i_tags[j] == i_tag)) begin
                hit = 1'b1;
                way = WIW'(j);
            end
        end
        o_hit     = hit;
        o_hit_way = way;
    end

    // Replacement: first invalid way, else the way of age one, else way zero.
    always_comb begin
        logic found;
        logic [WIW-1:0] way;
        found = 1'b0;
        way   = '0;
        for (int j = 0; j < WAYS; j++) begin
            if (!found && w_in_use[j] && !i_valid[j]) begin
                found = 1'b1;
                way   = WIW'(j);
            end
        end
        for (int j = 0; j < WAYS; j++) begin
            if (!found && w_in_use[j] && (i_age[j] == AGW'(1))) begin
                found = 1'b1;
                way   = WIW'(j);
            end
        end
        o_vic_way = way;
    end

    // Promotion: ways more recent than the touched one step down, the touched way goes on top.
    always_comb begin
        logic [AGW-1:0] old_age;
        old_age = i_age[i_touch];
        for (int j = 0; j < WAYS; j++) begin
            if (WIW'(j) == i_touch) begin
                o_age[j] = i_ways;
            end else if (w_in_use[j] && (i_age[j] > old_age)) begin
                o_age[j] = i_age[j] - AGW'(1);
            end else begin
                o_age[j] = i_age[j];
            end
        end
    end

endmodule

// ===== rtl/core/two_level_lru_cache_tag_model.sv =====
// ----------------------------------------------------------------------------
// Two-level inclusive LRU write-back cache tag model
// Each access word (kind, address) is looked up in the first level and, on
// a miss, in the second level; the word returned carries the hit flags.
//
// Input channel: i_valid / o_ready with i_kind and i_address. Output
// channel: o_valid / i_ready with o_l1_hit, o_l2_accessed and o_l2_hit.
// One result word follows each access word, in order.
// For each access the sequencer reads a set row, updates it and writes it
// back, for the lookup, an L1 back-invalidation, the L1 fill and an L2
// writeback as needed. Each set store has one registered read port. The
// sequencer returns to idle before the next access word is accepted.
// The result stays in an output register until taken; while the receiver
// stalls, no new access word is accepted.
// Configuration writes are taken at any edge with i_cfg_we high.
// After reset a clearing pass over every row of both set stores clears
// the line state; o_ready stays low until it ends.
// ----------------------------------------------------------------------------
module two_level_lru_cache_tag_model
    import tlc_pkg::*;
#(
    parameter int FIRST_WAYS   = 4,
    parameter int FIRST_SETS   = 64,
    parameter int SECOND_WAYS  = 8,
    parameter int SECOND_SETS  = 256,
    parameter int ADDRESS_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_kind,
    input  logic [31:0]           i_address,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_l1_hit,
    output logic                  o_l2_accessed,
    output logic                  o_l2_hit
);

    localparam int AW          = (ADDRESS_BITS < 32) ? ADDRESS_BITS : 32;
    localparam int IW1         = (FIRST_SETS > 1) ? $clog2(FIRST_SETS) : 1;
    localparam int IW2         = (SECOND_SETS > 1) ? $clog2(SECOND_SETS) : 1;
    localparam int WIW1        = (FIRST_WAYS > 1) ? $clog2(FIRST_WAYS) : 1;
    localparam int WIW2        = (SECOND_WAYS > 1) ? $clog2(SECOND_WAYS) : 1;
    localparam int AGW1        = $clog2(FIRST_WAYS + 1);
    localparam int AGW2        = $clog2(SECOND_WAYS + 1);
    localparam int L1_SET_LOG  = $clog2(FIRST_SETS + 1) - 1;
    localparam int L2_SET_LOG  = $clog2(SECOND_SETS + 1) - 1;
    localparam int L1_WAY_LOG  = $clog2(FIRST_WAYS + 1) - 1;
    localparam int L2_WAY_LOG  = $clog2(SECOND_WAYS + 1) - 1;
    // A rebuilt block number can be wider than an address after a geometry change.
    localparam int OBW         = AW + ((IW1 > IW2) ? IW1 : IW2);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_LOOK    = 9'b000000010,
        S_BINV_RD = 9'b000000100,
        S_BINV    = 9'b000001000,
        S_F1_RD   = 9'b000010000,
        S_F1      = 9'b000100000,
        S_WB_RD   = 9'b001000000,
        S_WB      = 9'b010000000,
        S_OUT     = 9'b100000000
    } t_state;

    // Configuration registers.
    logic [3:0] r_cfg_off;
    logic [2:0] r_cfg_l1_idx;
    logic [1:0] r_cfg_l1_way;
    logic [3:0] r_cfg_l2_idx;
    logic [1:0] r_cfg_l2_way;
    logic       r_cfg_wa;

    t_state r_state, n_state;
    logic [IW1-1:0] r_s1, r_os1;
    logic [IW2-1:0] r_s2, r_os2;
    logic [AW-1:0]  r_t1, r_t2, r_ot;
    logic [OBW-1:0] r_ob;
    logic           r_ot_big;
    logic           r_write;
    logic           r_res_l1, r_res_l2a, r_res_l2h;

    // Effective geometry.
    logic [3:0]      w_idx1, w_idx2;
    logic [2:0]      w_wlog1, w_wlog2;
    logic [AGW1-1:0] w_ways1;
    logic [AGW2-1:0] w_ways2;
    logic [IW1-1:0]  w_mask1;
    logic [IW2-1:0]  w_mask2;
    logic [AW-1:0]   w_block;
    logic [IW1-1:0]  w_s1, w_os1;
    logic [IW2-1:0]  w_s2, w_os2;
    logic [AW-1:0]   w_t1, w_t2;
    logic [OBW-1:0]  w_ot1, w_ot2;
    logic            w_noalloc;

    // Store and unit signals.
    logic busy1, busy2;
    logic [IW1-1:0] rd1_set, wr1_set;
    logic [IW2-1:0] rd2_set, wr2_set;
    logic wr1_en, wr2_en;
    logic [FIRST_WAYS-1:0][AW-1:0]    l1_tags, n1_tags;
    logic [FIRST_WAYS-1:0]            l1_valid, l1_dirty, n1_valid, n1_dirty;
    logic [FIRST_WAYS-1:0][AGW1-1:0]  l1_age, n1_age, u1_age;
    logic [SECOND_WAYS-1:0][AW-1:0]   l2_tags, n2_tags;
    logic [SECOND_WAYS-1:0]           l2_valid, l2_dirty, n2_valid, n2_dirty;
    logic [SECOND_WAYS-1:0][AGW2-1:0] l2_age, n2_age, u2_age;
    logic            u1_hit, u2_hit;
    logic [WIW1-1:0] u1_hit_way, u1_vic, touch1;
    logic [WIW2-1:0] u2_hit_way, u2_vic, touch2;
    logic [AW-1:0]   tag1, tag2;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_off    <= RST_BLOCK_OFFSET;
            r_cfg_l1_idx <= RST_L1_INDEX;
            r_cfg_l1_way <= RST_L1_WAY;
            r_cfg_l2_idx <= RST_L2_INDEX;
            r_cfg_l2_way <= RST_L2_WAY;
            r_cfg_wa     <= RST_WRITE_ALLOC;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BLOCK_OFFSET: r_cfg_off    <= i_cfg_data;
                CFG_L1_INDEX:     r_cfg_l1_idx <= i_cfg_data[2:0];
                CFG_L1_WAY:       r_cfg_l1_way <= i_cfg_data[1:0];
                CFG_L2_INDEX:     r_cfg_l2_idx <= i_cfg_data;
                CFG_L2_WAY:       r_cfg_l2_way <= i_cfg_data[1:0];
                CFG_WRITE_ALLOC:  r_cfg_wa     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Geometry reduced to what the arrays hold.
    assign w_idx1  = ({1'b0, r_cfg_l1_idx} > 4'(L1_SET_LOG)) ? 4'(L1_SET_LOG)
                                                              : {1'b0, r_cfg_l1_idx};
    assign w_idx2  = (r_cfg_l2_idx > 4'(L2_SET_LOG)) ? 4'(L2_SET_LOG) : r_cfg_l2_idx;
    assign w_wlog1 = ({1'b0, r_cfg_l1_way} > 3'(L1_WAY_LOG)) ? 3'(L1_WAY_LOG)
                                                              : {1'b0, r_cfg_l1_way};
    assign w_wlog2 = ({1'b0, r_cfg_l2_way} > 3'(L2_WAY_LOG)) ? 3'(L2_WAY_LOG)
                                                              : {1'b0, r_cfg_l2_way};
    assign w_ways1 = AGW1'(1) << w_wlog1;
    assign w_ways2 = AGW2'(1) << w_wlog2;
    assign w_mask1 = ~({IW1{1'b1}} << w_idx1);
    assign w_mask2 = ~({IW2{1'b1}} << w_idx2);

    // Address split for the incoming word and for a rebuilt block number.
    assign w_block = i_address[AW-1:0] >> r_cfg_off;
    assign w_s1    = w_block[IW1-1:0] & w_mask1;
    assign w_t1    = w_block >> w_idx1;
    assign w_s2    = w_block[IW2-1:0] & w_mask2;
    assign w_t2    = w_block >> w_idx2;
    assign w_os1   = r_ob[IW1-1:0] & w_mask1;
    assign w_ot1   = r_ob >> w_idx1;
    assign w_os2   = r_ob[IW2-1:0] & w_mask2;
    assign w_ot2   = r_ob >> w_idx2;

    assign w_noalloc = r_write && !r_cfg_wa;

    // Read row selection for each step.
    always_comb begin
        rd1_set = r_s1;
        rd2_set = r_s2;
        if (r_state == S_IDLE) begin
            rd1_set = w_s1;
            rd2_set = w_s2;
        end else if (r_state == S_BINV_RD) begin
            rd1_set = w_os1;
        end else if (r_state == S_WB_RD) begin
            rd2_set = w_os2;
        end
    end

    tlc_set_store #(
        .SETS (FIRST_SETS),
        .WAYS (FIRST_WAYS),
        .AGW  (AGW1),
        .TW   (AW)
    ) u_l1_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_set   (rd1_set),
        .o_tags     (l1_tags),
        .o_valid    (l1_valid),
        .o_dirty    (l1_dirty),
        .o_age      (l1_age),
        .i_wr_en    (wr1_en),
        .i_wr_set   (wr1_set),
        .i_wr_tags  (n1_tags),
        .i_wr_valid (n1_valid),
        .i_wr_dirty (n1_dirty),
        .i_wr_age   (n1_age),
        .o_busy     (busy1)
    );

    tlc_set_store #(
        .SETS (SECOND_SETS),
        .WAYS (SECOND_WAYS),
        .AGW  (AGW2),
        .TW   (AW)
    ) u_l2_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_set   (rd2_set),
        .o_tags     (l2_tags),
        .o_valid    (l2_valid),
        .o_dirty    (l2_dirty),
        .o_age      (l2_age),
        .i_wr_en    (wr2_en),
        .i_wr_set   (wr2_set),
        .i_wr_tags  (n2_tags),
        .i_wr_valid (n2_valid),
        .i_wr_dirty (n2_dirty),
        .i_wr_age   (n2_age),
        .o_busy     (busy2)
    );

    // Unit operands depend on the step in progress.
    assign tag1   = (r_state == S_BINV) ? r_ot : r_t1;
    assign touch1 = (r_state == S_F1) ? u1_vic : u1_hit_way;
    assign tag2   = (r_state == S_WB) ? r_ot : r_t2;
    assign touch2 = u2_hit ? u2_hit_way : u2_vic;

    tlc_way_unit #(
        .WAYS (FIRST_WAYS),
        .AGW  (AGW1),
        .TW   (AW)
    ) u_l1_unit (
        .i_ways    (w_ways1),
        .i_valid   (l1_valid),
        .i_age     (l1_age),
        .i_tags    (l1_tags),
        .i_tag     (tag1),
        .i_touch   (touch1),
        .o_hit     (u1_hit),
        .o_hit_way (u1_hit_way),
        .o_vic_way (u1_vic),
        .o_age     (u1_age)
    );

    tlc_way_unit #(
        .WAYS (SECOND_WAYS),
        .AGW  (AGW2),
        .TW   (AW)
    ) u_l2_unit (
        .i_ways    (w_ways2),
        .i_valid   (l2_valid),
        .i_age     (l2_age),
        .i_tags    (l2_tags),
        .i_tag     (tag2),
        .i_touch   (touch2),
        .o_hit     (u2_hit),
        .o_hit_way (u2_hit_way),
        .o_vic_way (u2_vic),
        .o_age     (u2_age)
    );

    // Row updates written back at the end of each step. A rebuilt tag wider
    // than any stored tag matches nothing, so no update is made for it.
    always_comb begin
        wr1_en   = 1'b0;
        wr1_set  = r_s1;
        n1_tags  = l1_tags;
        n1_valid = l1_valid;
        n1_dirty = l1_dirty;
        n1_age   = l1_age;
        wr2_en   = 1'b0;
        wr2_set  = r_s2;
        n2_tags  = l2_tags;
        n2_valid = l2_valid;
        n2_dirty = l2_dirty;
        n2_age   = l2_age;
        case (r_state)
            S_LOOK: begin
                if (u1_hit) begin
                    wr1_en = 1'b1;
                    n1_age = u1_age;
                    if (r_write) begin
                        n1_dirty[u1_hit_way] = 1'b1;
                    end
                end else if (u2_hit) begin
                    wr2_en = 1'b1;
                    n2_age = u2_age;
                    if (w_noalloc) begin
                        n2_dirty[u2_hit_way] = 1'b1;
                    end
                end else if (!w_noalloc) begin
                    wr2_en           = 1'b1;
                    n2_tags[u2_vic]  = r_t2;
                    n2_valid[u2_vic] = 1'b1;
                    n2_dirty[u2_vic] = 1'b0;
                    n2_age           = u2_age;
                end
            end
            S_BINV: begin
                wr1_en  = u1_hit && !r_ot_big;
                wr1_set = r_os1;
                n1_valid[u1_hit_way] = 1'b0;
                n1_dirty[u1_hit_way] = 1'b0;
            end
            S_F1: begin
                wr1_en           = 1'b1;
                n1_tags[u1_vic]  = r_t1;
                n1_valid[u1_vic] = 1'b1;
                n1_dirty[u1_vic] = r_write;
                n1_age           = u1_age;
            end
            S_WB: begin
                wr2_en  = u2_hit && !r_ot_big;
                wr2_set = r_os2;
                n2_dirty[u2_hit_way] = 1'b1;
                n2_age  = u2_age;
            end
            default: ;
        endcase
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (u1_hit || w_noalloc) begin
                    n_state = S_OUT;
                end else if (!u2_hit && l2_valid[u2_vic]) begin
                    n_state = S_BINV_RD;
                end else begin
                    n_state = S_F1_RD;
                end
            end
            S_BINV_RD: n_state = S_BINV;
            S_BINV:    n_state = S_F1_RD;
            S_F1_RD:   n_state = S_F1;
            S_F1: begin
                if (l1_valid[u1_vic] && l1_dirty[u1_vic]) begin
                    n_state = S_WB_RD;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_WB_RD:   n_state = S_WB;
            S_WB:      n_state = S_OUT;
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Access fields, victim block numbers and result flags.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_valid && o_ready) begin
            r_s1    <= w_s1;
            r_t1    <= w_t1;
            r_s2    <= w_s2;
            r_t2    <= w_t2;
            r_write <= (i_kind == KIND_WRITE);
        end
        if (r_state == S_LOOK) begin
            r_res_l1  <= u1_hit;
            r_res_l2a <= !u1_hit;
            r_res_l2h <= !u1_hit && u2_hit;
            r_ob      <= (OBW'(l2_tags[u2_vic]) << w_idx2) | OBW'(r_s2);
        end
        if (r_state == S_F1) begin
            r_ob <= (OBW'(l1_tags[u1_vic]) << w_idx1) | OBW'(r_s1);
        end
        if (r_state == S_BINV_RD) begin
            r_os1    <= w_os1;
            r_ot     <= w_ot1[AW-1:0];
            r_ot_big <= |w_ot1[OBW-1:AW];
        end
        if (r_state == S_WB_RD) begin
            r_os2    <= w_os2;
            r_ot     <= w_ot2[AW-1:0];
            r_ot_big <= |w_ot2[OBW-1:AW];
        end
    end

    assign o_ready       = (r_state == S_IDLE) && !busy1 && !busy2;
    assign o_valid       = (r_state == S_OUT);
    assign o_l1_hit      = r_res_l1;
    assign o_l2_accessed = r_res_l2a;
    assign o_l2_hit      = r_res_l2h;

`ifndef ASSERT_OFF
    // An accepted word always starts with the lookup step.
    a_accept_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_LOOK))
        else $error("accepted word did not enter lookup");

    // A first-level hit never reports a second-level lookup.
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_l1_hit != o_l2_accessed) && !(o_l2_hit && !o_l2_accessed)))
        else $error("inconsistent hit flags");

    // No store update is issued during the clearing pass.
    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy1 || busy2) |-> (!wr1_en && !wr2_en))
        else $error("store written during clearing pass");

    // A word is not taken while a result is waiting.
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input ready while result pending");
`endif

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-level LRU cache tag model testbench
// Drives access words through a bursty valid/ready driver, checks every result
// word against a cycle-free tag predictor, and walks through several cache
// geometries and allocation policies, reconfiguring only when the block idles.
// ----------------------------------------------------------------------------
module tb_top
    import tlc_pkg::*;
();

    localparam int L1W = 4;
    localparam int L1S = 64;
    localparam int L2W = 8;
    localparam int L2S = 256;
    localparam int RUN_LIMIT = 2_000_000;

    typedef struct packed {
        logic        kind;
        logic [31:0] address;
    } t_access;

    typedef struct packed {
        logic l1_hit;
        logic l2_accessed;
        logic l2_hit;
    } t_flags;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_ready;
    logic                  i_kind;
    logic [31:0]           i_address;
    logic                  o_valid;
    logic                  i_ready;
    logic                  o_l1_hit;
    logic                  o_l2_accessed;
    logic                  o_l2_hit;

    two_level_lru_cache_tag_model uut (.*);

    // Predictor state: tag arrays, valid/dirty bits and ages per level.
    logic [31:0] l1_tag [L1S*L1W];
    logic        l1_vld [L1S*L1W];
    logic        l1_drt [L1S*L1W];
    int          l1_age [L1S*L1W];
    logic [31:0] l2_tag [L2S*L2W];
    logic        l2_vld [L2S*L2W];
    logic        l2_drt [L2S*L2W];
    int          l2_age [L2S*L2W];

    int unsigned cur_offset, cur_l1_idx, cur_l1_way, cur_l2_idx, cur_l2_way;
    int unsigned cur_walloc;

    t_access pending_words [$];
    t_flags  expected_flags [$];
    int      errors = 0;
    int      cycle_count = 0;

    function automatic int unsigned clip_bits(int unsigned b, int unsigned lim);
        while (b > 0 && (1 << b) > lim) b--;
        return b;
    endfunction

    // Find the way holding the tag in a set; -1 when absent.
    function automatic int find_way(bit second, int unsigned set, int unsigned ways,
                                    logic [63:0] tag);
        int base;
        base = second ? set * L2W : set * L1W;
        for (int w = 0; w < ways; w++) begin
            if (second ? (l2_vld[base+w] && l2_tag[base+w] == tag)
                       : (l1_vld[base+w] && l1_tag[base+w] == tag))
                return w;
        end
        return -1;
    endfunction

    // Make a way most recent, aging the younger lines of its set.
    function automatic void touch_way(bit second, int unsigned set, int unsigned ways,
                                      int unsigned way);
        int base;
        int prev;
        base = second ? set * L2W : set * L1W;
        prev = second ? l2_age[base+way] : l1_age[base+way];
        for (int j = 0; j < ways; j++) begin
            if (j != way) begin
                if (second && l2_age[base+j] > prev) l2_age[base+j]--;
                if (!second && l1_age[base+j] > prev) l1_age[base+j]--;
            end
        end
        if (second) l2_age[base+way] = ways;
        else l1_age[base+way] = ways;
    endfunction

    // First invalid way, else the oldest (age one), else way zero.
    function automatic int unsigned pick_victim(bit second, int unsigned set,
                                                int unsigned ways);
        int base;
        base = second ? set * L2W : set * L1W;
        for (int j = 0; j < ways; j++)
            if (!(second ? l2_vld[base+j] : l1_vld[base+j])) return j;
        for (int j = 0; j < ways; j++)
            if ((second ? l2_age[base+j] : l1_age[base+j]) == 1) return j;
        return 0;
    endfunction

    // Compute the hit flags of one access and update the predicted tag state.
    function automatic t_flags cache_access(t_access acc);
        t_flags r;
        int unsigned w1, w2, ib1, ib2, s1, s2, os, v1, v2, p;
        logic [31:0] blk, t1, t2;
        logic [63:0] ob, ot;
        bit wr, fill;
        int h;
        wr  = (acc.kind == KIND_WRITE);
        w1  = 1 << clip_bits(cur_l1_way, L1W);
        w2  = 1 << clip_bits(cur_l2_way, L2W);
        ib1 = clip_bits(cur_l1_idx, L1S);
        ib2 = clip_bits(cur_l2_idx, L2S);
        blk = acc.address >> cur_offset;
        s1 = blk & ((1 << ib1) - 1);
        t1 = blk >> ib1;
        s2 = blk & ((1 << ib2) - 1);
        t2 = blk >> ib2;
        r = '0;
        fill = 0;
        h = find_way(0, s1, w1, 64'(t1));
        if (h >= 0) begin
            if (wr) l1_drt[s1*L1W+h] = 1;
            touch_way(0, s1, w1, h);
            r.l1_hit = 1;
            return r;
        end
        r.l2_accessed = 1;
        h = find_way(1, s2, w2, 64'(t2));
        if (h >= 0) begin
            r.l2_hit = 1;
            touch_way(1, s2, w2, h);
            if (wr && cur_walloc == 0) l2_drt[s2*L2W+h] = 1;
            else fill = 1;
        end else if (!(wr && cur_walloc == 0)) begin
            v2 = pick_victim(1, s2, w2);
            p = s2 * L2W + v2;
            if (l2_vld[p]) begin
                // Back-invalidate the L1 copy of the evicted L2 line.
                ob = (64'(l2_tag[p]) << ib2) | 64'(s2);
                os = ob & ((1 << ib1) - 1);
                ot = ob >> ib1;
                h = find_way(0, os, w1, ot);
                if (h >= 0) begin
                    l1_vld[os*L1W+h] = 0;
                    l1_drt[os*L1W+h] = 0;
                end
            end
            l2_tag[p] = t2;
            l2_vld[p] = 1;
            l2_drt[p] = 0;
            touch_way(1, s2, w2, v2);
            fill = 1;
        end
        if (fill) begin
            v1 = pick_victim(0, s1, w1);
            p = s1 * L1W + v1;
            if (l1_vld[p] && l1_drt[p]) begin
                // Dirty L1 victim is written back into its L2 line.
                ob = (64'(l1_tag[p]) << ib1) | 64'(s1);
                os = ob & ((1 << ib2) - 1);
                ot = ob >> ib2;
                h = find_way(1, os, w2, ot);
                if (h >= 0) begin
                    l2_drt[os*L2W+h] = 1;
                    touch_way(1, os, w2, h);
                end
            end
            l1_tag[p] = t1;
            l1_vld[p] = 1;
            l1_drt[p] = wr;
            touch_way(0, s1, w1, v1);
        end
        return r;
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Driver: bursts of words with random gaps between them.
    int burst_left, gap_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0;
            i_kind <= 0;
            i_address <= 0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (!i_valid || o_ready) begin
            if (i_valid && o_ready) expected_flags.push_back(cache_access({i_kind, i_address}));
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid <= 0;
            end else if (pending_words.size() > 0) begin
                t_access a;
                a = pending_words.pop_front();
                i_valid <= 1;
                i_kind <= a.kind;
                i_address <= a.address;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_valid <= 0;
            end
        end
    end

    // Receiver stall pattern: phases of full speed and random stalling.
    int stall_mode;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 0;
            stall_mode <= 0;
        end else begin
            if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: i_ready <= 1;
                1: i_ready <= ($urandom_range(0, 3) != 0);
                default: i_ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // Monitor: compare each result word with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_flags.size() == 0) begin
                $error("result word with no access outstanding");
                errors++;
            end else begin
                t_flags e;
                e = expected_flags.pop_front();
                if (o_l1_hit !== e.l1_hit) begin
                    $error("l1_hit expected %0d actual %0d", e.l1_hit, o_l1_hit);
                    errors++;
                end
                if (o_l2_accessed !== e.l2_accessed) begin
                    $error("l2_accessed expected %0d actual %0d", e.l2_accessed,
                           o_l2_accessed);
                    errors++;
                end
                if (o_l2_hit !== e.l2_hit) begin
                    $error("l2_hit expected %0d actual %0d", e.l2_hit, o_l2_hit);
                    errors++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("two_level_lru_cache_tag_model test failed");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_idx idx, int unsigned value);
        @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= CFG_DATA_W'(value);
        case (idx)
            CFG_BLOCK_OFFSET: cur_offset = value & 15;
            CFG_L1_INDEX:     cur_l1_idx = value & 7;
            CFG_L1_WAY:       cur_l1_way = value & 3;
            CFG_L2_INDEX:     cur_l2_idx = value & 15;
            CFG_L2_WAY:       cur_l2_way = value & 3;
            CFG_WRITE_ALLOC:  cur_walloc = value & 1;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    // Wait until every queued word is sent and every result has arrived.
    task automatic drain();
        while (pending_words.size() > 0 || i_valid || expected_flags.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Address built from a small pool of blocks so sets see real reuse.
    function automatic t_access rand_access(int unsigned pool_bits);
        t_access a;
        a.kind = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) == 0) a.address = $urandom();
        else a.address = ($urandom() & ((1 << pool_bits) - 1)) << cur_offset
                         | ($urandom() & ((1 << cur_offset) - 1));
        return a;
    endfunction

    task automatic run_phase(int unsigned count, int unsigned pool_bits);
        for (int i = 0; i < count; i++) pending_words.push_back(rand_access(pool_bits));
        drain();
    endtask

    initial begin
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_idx = CFG_BLOCK_OFFSET;
        i_cfg_data = 0;
        foreach (l1_vld[k]) begin
            l1_vld[k] = 0; l1_drt[k] = 0; l1_age[k] = 0; l1_tag[k] = 0;
        end
        foreach (l2_vld[k]) begin
            l2_vld[k] = 0; l2_drt[k] = 0; l2_age[k] = 0; l2_tag[k] = 0;
        end
        cur_offset = RST_BLOCK_OFFSET;
        cur_l1_idx = RST_L1_INDEX;
        cur_l1_way = RST_L1_WAY;
        cur_l2_idx = RST_L2_INDEX;
        cur_l2_way = RST_L2_WAY;
        cur_walloc = RST_WRITE_ALLOC;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: address extremes, both kinds, hits, misses, write-no-allocate.
        pending_words.push_back('{1'b0, 32'h0000_0000});
        pending_words.push_back('{1'b0, 32'h0000_0000});
        pending_words.push_back('{1'b1, 32'h0000_0003});
        pending_words.push_back('{1'b1, 32'hFFFF_FFFF});
        pending_words.push_back('{1'b0, 32'hFFFF_FFFC});
        pending_words.push_back('{1'b0, 32'hAAAA_AAAA});
        pending_words.push_back('{1'b1, 32'h5555_5555});
        for (int i = 0; i < 6; i++) pending_words.push_back('{1'b1, 32'(i) << 10});
        drain();
        write_reg(CFG_WRITE_ALLOC, 0);
        pending_words.push_back('{1'b1, 32'h1234_5600});
        pending_words.push_back('{1'b1, 32'h0000_0400});
        pending_words.push_back('{1'b0, 32'h1234_5600});
        drain();

        // Random phases over several geometries, extremes included.
        run_phase(200, 12);
        write_reg(CFG_WRITE_ALLOC, 1);
        write_reg(CFG_L1_INDEX, 0);
        write_reg(CFG_L1_WAY, 0);
        write_reg(CFG_L2_INDEX, 0);
        write_reg(CFG_L2_WAY, 0);
        write_reg(CFG_BLOCK_OFFSET, 0);
        run_phase(200, 4);
        write_reg(CFG_BLOCK_OFFSET, 8);
        write_reg(CFG_L1_INDEX, 7);
        write_reg(CFG_L1_WAY, 3);
        write_reg(CFG_L2_INDEX, 15);
        write_reg(CFG_L2_WAY, 3);
        run_phase(250, 11);
        write_reg(CFG_L1_INDEX, 2);
        write_reg(CFG_L2_INDEX, 3);
        write_reg(CFG_L1_WAY, 1);
        write_reg(CFG_L2_WAY, 2);
        write_reg(CFG_BLOCK_OFFSET, 4);
        run_phase(250, 7);
        write_reg(CFG_WRITE_ALLOC, 0);
        run_phase(200, 7);
        write_reg(CFG_L1_INDEX, 1);
        write_reg(CFG_L2_INDEX, 5);
        write_reg(CFG_WRITE_ALLOC, 1);
        run_phase(200, 8);
        for (int k = 0; k < 6; k++) write_reg(t_cfg_idx'(k), $urandom_range(0, 15));
        run_phase(200, 9);

        if (errors == 0) $display("two_level_lru_cache_tag_model test passed");
        else $display("two_level_lru_cache_tag_model test failed");
        $finish;
    end

endmodule
